// File: sv/skt_pkg.sv
package skt_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_W     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 6;
    localparam int POS_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef struct packed {
        logic  capture;
        t_mode mode;
        t_cmd  cmd;
        logic  key_signed;
    } t_cell_ctl;

    typedef struct packed {
        logic le;
        logic lt;
    } t_cell_flags;

    // Flipping the sign bit makes unsigned order match two's complement order.
    function automatic logic [KEY_W-1:0] ord_key(input logic [KEY_W-1:0] key,
                                                 input logic key_signed);
        ord_key = key ^ {key_signed, {(KEY_W - 1){1'b0}}};
    endfunction

endpackage

// File: sv/skt_if.sv
interface skt_in_if;
    logic                         valid;
    logic                         ready;
    logic [skt_pkg::CMD_W-1:0]    cmd;
    logic [skt_pkg::KEY_W-1:0]    key;
    logic [skt_pkg::INDEX_W-1:0]  index;

    modport source (output valid, output cmd, output key, output index, input ready);
    modport sink (input valid, input cmd, input key, input index, output ready);
endinterface

interface skt_out_if;
    logic                          valid;
    logic                          ready;
    logic [skt_pkg::STATUS_W-1:0]  status;
    logic [skt_pkg::POS_W-1:0]     position;
    logic [skt_pkg::VALUE_W-1:0]   value;
    logic [skt_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output status, output position, output value,
                    output count, input ready);
    modport sink (input valid, input status, input position, input value,
                  input count, output ready);
endinterface

// File: sv/skt_cell.sv
module skt_cell (
    input  logic                        i_clk,
    input  skt_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_valid,
    input  logic                        i_sel,
    input  logic [skt_pkg::KEY_W-1:0]   i_cmp_key,
    input  logic [skt_pkg::KEY_W-1:0]   i_new_key,
    input  logic [skt_pkg::KEY_W-1:0]   i_left_key,
    input  logic [skt_pkg::KEY_W-1:0]   i_right_key,
    input  skt_pkg::t_cell_flags        i_left,
    output skt_pkg::t_cell_flags        o_flags,
    output logic [skt_pkg::KEY_W-1:0]   o_key,
    output logic                        o_hit
);

    logic [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::KEY_W-1:0] n_key;
    logic                      r_le;
    logic                      r_lt;
    logic                      r_eq;
    logic                      r_sel;
    logic [skt_pkg::KEY_W-1:0] own_ord;
    logic [skt_pkg::KEY_W-1:0] cmp_ord;
    logic                      ins_here;

    assign own_ord = skt_pkg::ord_key(r_key, i_ctl.key_signed);
    assign cmp_ord = skt_pkg::ord_key(i_cmp_key, i_ctl.key_signed);
    assign ins_here = !r_le && i_left.le;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_le  <= i_valid && (own_ord <= cmp_ord);
            r_lt  <= i_valid && (own_ord < cmp_ord);
            r_eq  <= i_valid && (own_ord == cmp_ord);
            r_sel <= i_sel;
        end
        r_key <= n_key;
    end

    always_comb begin
        unique case (i_ctl.mode)
            skt_pkg::MODE_HOLD: begin
                n_key = r_key;
            end
            skt_pkg::MODE_INSERT: begin
                if (ins_here) begin
                    n_key = i_new_key;
                end else if (!i_left.le) begin
                    n_key = i_left_key;
                end else begin
                    n_key = r_key;
                end
            end
            skt_pkg::MODE_REMOVE: begin
                n_key = r_lt ? r_key : i_right_key;
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_comb begin
        unique case (i_ctl.cmd)
            skt_pkg::CMD_INSERT: o_hit = ins_here;
            skt_pkg::CMD_REMOVE: o_hit = r_eq && i_left.lt;
            skt_pkg::CMD_READ:   o_hit = r_sel;
            skt_pkg::CMD_CLEAR:  o_hit = 1'b0;
        endcase
    end

    assign o_flags.le = r_le;
    assign o_flags.lt = r_lt;
    assign o_key = r_key;

endmodule

// File: sv/sorted_key_table.sv
// Sorted key table: a row of cells keeps up to 64 keys in ascending order, compared
// unsigned or as two's complement as the key_signed register selects. Each transaction
// takes two steps: on accept every cell compares its key with the incoming one at once
// and registers the outcome; on completion an insert or removal shifts the cells by one
// place toward or away from the insertion or removal point while the result is formed
// from the cell that hit. The result waits in an output register; while it is not taken,
// the next transaction cannot complete. A full table drops an insert with a full status.
module sorted_key_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    skt_in_if.sink     i_in,
    skt_out_if.source  o_out
);

    localparam int DEPTH = skt_pkg::DEPTH;
    localparam int KEY_W = skt_pkg::KEY_W;
    localparam int IDX_W = skt_pkg::IDX_W;
    localparam int CNT_W = skt_pkg::CNT_W;

    logic                         r_key_signed;
    logic                         r_busy;
    skt_pkg::t_cmd                r_cmd;
    logic [KEY_W-1:0]             r_key;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;

    logic                         r_out_valid;
    skt_pkg::t_status             r_status;
    skt_pkg::t_status             n_status;
    logic [skt_pkg::POS_W-1:0]    r_position;
    logic [skt_pkg::POS_W-1:0]    n_position;
    logic [skt_pkg::VALUE_W-1:0]  r_value;
    logic [skt_pkg::VALUE_W-1:0]  n_value;
    logic [skt_pkg::COUNT_W-1:0]  r_count_out;

    logic                         accept;
    logic                         done;
    logic                         full;
    logic                         found;
    logic [IDX_W-1:0]             hit_pos;
    logic [KEY_W-1:0]             hit_key;
    skt_pkg::t_cell_ctl           ctl;

    logic [KEY_W-1:0]             cell_key   [DEPTH];
    skt_pkg::t_cell_flags         cell_flags [DEPTH];
    logic [DEPTH-1:0]             cell_hit;

    assign i_in.ready = !r_busy;
    assign accept = i_in.valid && !r_busy;
    assign done = r_busy && (!r_out_valid || o_out.ready);
    assign full = (r_count == CNT_W'(DEPTH));
    assign found = |cell_hit;

    always_comb begin
        ctl.capture = accept;
        ctl.cmd = r_cmd;
        ctl.key_signed = r_key_signed;
        if (!done) begin
            ctl.mode = skt_pkg::MODE_HOLD;
        end else if (r_cmd == skt_pkg::CMD_INSERT && !full) begin
            ctl.mode = skt_pkg::MODE_INSERT;
        end else if (r_cmd == skt_pkg::CMD_REMOVE && found) begin
            ctl.mode = skt_pkg::MODE_REMOVE;
        end else begin
            ctl.mode = skt_pkg::MODE_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        skt_pkg::t_cell_flags left_flags;
        logic [KEY_W-1:0]     left_key;
        logic [KEY_W-1:0]     right_key;
        logic                 entry_valid;
        logic                 index_sel;

        if (g == 0) begin : g_first
            assign left_flags = '{le: 1'b1, lt: 1'b1};
            assign left_key = '0;
        end else begin : g_inner
            assign left_flags = cell_flags[g-1];
            assign left_key = cell_key[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_body
            assign right_key = cell_key[g+1];
        end

        assign entry_valid = (CNT_W'(g) < r_count);
        assign index_sel = entry_valid && (CNT_W'(i_in.index) == CNT_W'(g));

        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_valid     (entry_valid),
            .i_sel       (index_sel),
            .i_cmp_key   (i_in.key),
            .i_new_key   (r_key),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .i_left      (left_flags),
            .o_flags     (cell_flags[g]),
            .o_key       (cell_key[g]),
            .o_hit       (cell_hit[g])
        );
    end

    // At most one cell reports a hit, so an OR over the row selects it.
    always_comb begin
        hit_pos = '0;
        hit_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_hit[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
                hit_key = hit_key | cell_key[i];
            end
        end
    end

    always_comb begin
        n_status = skt_pkg::ST_OK;
        n_position = '0;
        n_value = '0;
        n_count = r_count;
        unique case (r_cmd)
            skt_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = skt_pkg::ST_FULL;
                end else begin
                    n_position = skt_pkg::POS_W'(hit_pos);
                    n_count = r_count + CNT_W'(1);
                end
            end
            skt_pkg::CMD_REMOVE: begin
                if (found) begin
                    n_position = skt_pkg::POS_W'(hit_pos);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = skt_pkg::ST_MISS;
                end
            end
            skt_pkg::CMD_READ: begin
                if (found) begin
                    n_position = skt_pkg::POS_W'(hit_pos);
                    n_value = skt_pkg::VALUE_W'(hit_key);
                end else begin
                    n_status = skt_pkg::ST_MISS;
                end
            end
            skt_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_signed <= 1'b0;
            r_busy <= 1'b0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_signed <= i_cfg_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_count <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= skt_pkg::t_cmd'(i_in.cmd);
            r_key <= i_in.key;
        end
        if (done) begin
            r_status <= n_status;
            r_position <= n_position;
            r_value <= n_value;
            r_count_out <= skt_pkg::COUNT_W'(n_count);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.position = r_position;
    assign o_out.value = r_value;
    assign o_out.count = r_count_out;

endmodule
